FILE: hdl/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the triangle depth rasterizer.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int DEF_MAP_WIDTH  = 256;
  localparam int DEF_MAP_HEIGHT = 256;

  localparam int COORD_W   = 16;
  localparam int DEPTH_W   = 16;
  localparam int PIXCNT_W  = 17;
  localparam int PIX_W     = 8;
  localparam int CMD_W     = 2;
  localparam int S_TDATA_W = 160;
  localparam int M_TDATA_W = 40;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = 16'hFFFF;

  localparam logic [CMD_W-1:0] CMD_RASTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  typedef enum logic [1:0] {
    KIND_RASTER,
    KIND_CLEAR,
    KIND_READ,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by_pos;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic [DEPTH_W-1:0]         depth_a;
    logic [DEPTH_W-1:0]         depth_b;
    logic [DEPTH_W-1:0]         depth_c;
    logic [PIX_W-1:0]           read_col;
    logic [PIX_W-1:0]           read_row;
  } item_t;

  typedef struct packed {
    logic ready;      // back end takes the queue head
    logic init_busy;  // clearing pass after reset
  } back_stat_t;

endpackage

FILE: hdl/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front
// Input side: accepts command words, classifies them and queues them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module trd_front
  import trd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [CMD_W-1:0]     s_tuser_i,
  input  back_stat_t           stat_i,
  output logic                 item_valid_o,
  output item_t                item_o
);

  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.ax       = $signed(s_tdata_i[15:0]);
    item_in.ay       = $signed(s_tdata_i[31:16]);
    item_in.bx       = $signed(s_tdata_i[47:32]);
    item_in.by_pos   = $signed(s_tdata_i[63:48]);
    item_in.cx       = $signed(s_tdata_i[79:64]);
    item_in.cy       = $signed(s_tdata_i[95:80]);
    item_in.depth_a  = s_tdata_i[111:96];
    item_in.depth_b  = s_tdata_i[127:112];
    item_in.depth_c  = s_tdata_i[143:128];
    item_in.read_col = s_tdata_i[151:144];
    item_in.read_row = s_tdata_i[159:152];
    case (s_tuser_i)
      CMD_RASTER: item_in.kind = KIND_RASTER;
      CMD_CLEAR:  item_in.kind = KIND_CLEAR;
      CMD_READ:   item_in.kind = KIND_READ;
      default:    item_in.kind = KIND_NOP;
    endcase
  end

  assign s_tready_o   = (cnt_q != 2'd2) && !stat_i.init_busy;
  assign push         = s_tvalid_i && s_tready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && stat_i.ready;
  assign item_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= item_in;
  end

endmodule

FILE: hdl/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back
// Execution side: triangle setup on one shared multiplier, bounding-box
// walk with incremental edge functions, bit-serial depth divide, depth
// store with clear sweep, and the result register.
// ----------------------------------------------------------------------------
module trd_back
  import trd_pkg::*;
#(
  parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = DEF_MAP_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  item_t               item_i,
  output back_stat_t          stat_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [PIXCNT_W-1:0] pixels_written_o,
  output logic [DEPTH_W-1:0]  read_depth_o
);

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int YW    = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam int BW    = 14;   // floor/ceil pixel bounds, signed
  localparam int DW    = 17;   // vertex differences
  localparam int CXW   = 18;   // pixel center offset
  localparam int MA_W  = 34;
  localparam int MB_W  = 18;
  localparam int MP_W  = 52;
  localparam int DETW  = 34;
  localparam int EW    = 40;
  localparam int NW    = 56;
  localparam int QW    = DEPTH_W;

  localparam logic signed [BW-1:0] XLIM = BW'(MAP_WIDTH - 1);
  localparam logic signed [BW-1:0] YLIM = BW'(MAP_HEIGHT - 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CLEAR  = 9'b000000010,
    ST_SETUP  = 9'b000000100,
    ST_PIX    = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_RDADDR = 9'b001000000,
    ST_RDWAIT = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   init_q;
  logic [AW-1:0] clr_q;
  logic [3:0]    step_q;
  logic          m_valid_q;

  item_t item_q;
  logic signed [DW-1:0]   a0_q, b0_q, a1_q, b1_q, c1_q, ga_q, gb_q;
  logic [XW-1:0]          minx_q, maxx_q, px_q;
  logic [YW-1:0]          miny_q, maxy_q, py_q;
  logic                   empty_q;
  logic signed [CXW-1:0]  cx0_q, cy0_q;
  logic signed [MP_W-1:0] prod_q;
  logic signed [DETW-1:0] det_q;
  logic signed [MA_W-1:0] gx_q, gy_q;
  logic signed [EW-1:0]   e0_q, e1_q, e0r_q, e1r_q;
  logic signed [NW-1:0]   n_q, nr_q;
  logic [AW-1:0]          addr_row_q, addr_q;
  logic [NW-1:0]          rem_q, dvs_q;
  logic [QW-1:0]          quo_q;
  logic [3:0]             bit_q;
  logic [PIXCNT_W-1:0]    cnt_q, res_cnt_q;
  logic [DEPTH_W-1:0]     rdval_q, res_depth_q, rd_data_q;

  logic [DEPTH_W-1:0] depth_mem [DEPTH];

  // bounds of the incoming item
  logic signed [COORD_W-1:0] xmn, xmx, ymn, ymx;
  logic signed [COORD_W:0]   xce, yce;
  logic signed [BW-1:0]      minx_c, maxx_c, miny_c, maxy_c;

  always_comb begin
    xmn = (item_i.ax < item_i.bx) ? item_i.ax : item_i.bx;
    xmn = (xmn < item_i.cx) ? xmn : item_i.cx;
    xmx = (item_i.ax > item_i.bx) ? item_i.ax : item_i.bx;
    xmx = (xmx > item_i.cx) ? xmx : item_i.cx;
    ymn = (item_i.ay < item_i.by_pos) ? item_i.ay : item_i.by_pos;
    ymn = (ymn < item_i.cy) ? ymn : item_i.cy;
    ymx = (item_i.ay > item_i.by_pos) ? item_i.ay : item_i.by_pos;
    ymx = (ymx > item_i.cy) ? ymx : item_i.cy;
    xce = ((COORD_W+1)'(xmx) + 17'sd15) >>> 4;
    yce = ((COORD_W+1)'(ymx) + 17'sd15) >>> 4;
    minx_c = BW'(xmn >>> 4);
    miny_c = BW'(ymn >>> 4);
    maxx_c = BW'(xce);
    maxy_c = BW'(yce);
    if (minx_c < 0)    minx_c = '0;
    if (miny_c < 0)    miny_c = '0;
    if (maxx_c > XLIM) maxx_c = XLIM;
    if (maxy_c > YLIM) maxy_c = YLIM;
  end

  // shared setup multiplier, operands by step
  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;

  always_comb begin
    opa = '0;
    opb = '0;
    case (step_q)
      4'd0:    begin opa = MA_W'(a0_q); opb = MB_W'(b1_q); end
      4'd1:    begin opa = MA_W'(b0_q); opb = MB_W'(c1_q); end
      4'd4:    begin opa = MA_W'(a0_q); opb = MB_W'(ga_q); end
      4'd5:    begin opa = MA_W'(a1_q); opb = MB_W'(gb_q); end
      4'd6:    begin opa = MA_W'(b0_q); opb = MB_W'(ga_q); end
      4'd7:    begin opa = MA_W'(b1_q); opb = MB_W'(gb_q); end
      4'd8:    begin opa = MA_W'(a0_q); opb = cx0_q; end
      4'd9:    begin opa = MA_W'(b0_q); opb = cy0_q; end
      4'd10:   begin opa = MA_W'(a1_q); opb = cx0_q; end
      4'd11:   begin opa = MA_W'(b1_q); opb = cy0_q; end
      4'd12:   begin opa = gx_q; opb = cx0_q; end
      4'd13:   begin opa = gy_q; opb = cy0_q; end
      4'd14:   begin opa = MA_W'(det_q); opb = $signed({2'b00, item_q.depth_c}); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // walk helpers
  logic signed [EW-1:0] e2;
  logic                 covered, last_x, last_y, adv, div_ge, rd_ok;
  logic signed [EW-1:0] ex0, ex1, ey0, ey1;
  logic signed [NW-1:0] nx, ny;

  always_comb begin
    e2      = EW'(det_q) - e0_q - e1_q;
    covered = !e0_q[EW-1] && !e1_q[EW-1] && !e2[EW-1];
    last_x  = (px_q == maxx_q);
    last_y  = (py_q == maxy_q);
    adv     = (state_q == ST_PIX && !covered) || (state_q == ST_WRITE);
    ex0     = EW'(a0_q) <<< 4;
    ex1     = EW'(a1_q) <<< 4;
    ey0     = EW'(b0_q) <<< 4;
    ey1     = EW'(b1_q) <<< 4;
    nx      = NW'(gx_q) <<< 4;
    ny      = NW'(gy_q) <<< 4;
    div_ge  = (rem_q >= dvs_q);
    rd_ok   = (32'(item_q.read_col) < MAP_WIDTH) && (32'(item_q.read_row) < MAP_HEIGHT);
  end

  // depth store ports
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [DEPTH_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = quo_q;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = FAR_DEPTH;
      end
      ST_PIX:    mem_re = covered;
      ST_WRITE:  mem_we = (quo_q < rd_data_q);
      ST_RDADDR: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(32'(item_q.read_row) * MAP_WIDTH + 32'(item_q.read_col));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= depth_mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          case (item_i.kind)
            KIND_RASTER: state_d = ST_SETUP;
            KIND_CLEAR:  state_d = ST_CLEAR;
            KIND_READ:   state_d = ST_RDADDR;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = init_q ? ST_IDLE : ST_DONE;
      ST_SETUP: begin
        if (step_q == 4'd3 && (det_q == '0 || empty_q)) state_d = ST_DONE;
        else if (step_q == 4'd15)                        state_d = ST_PIX;
      end
      ST_PIX:    if (covered) state_d = ST_DIV;
                 else if (last_x && last_y) state_d = ST_DONE;
      ST_DIV:    if (bit_q == 4'd0) state_d = ST_WRITE;
      ST_WRITE:  state_d = (last_x && last_y) ? ST_DONE : ST_PIX;
      ST_RDADDR: state_d = ST_RDWAIT;
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE:   if (!m_valid_q || m_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      init_q    <= 1'b1;
      clr_q     <= '0;
      step_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_q  <= '0;
          init_q <= 1'b0;
        end
      end
      if (state_q == ST_SETUP) step_q <= step_q + 4'd1;
      else                     step_q <= '0;
      if (state_q == ST_DONE && (!m_valid_q || m_tready_i)) m_valid_q <= 1'b1;
      else if (m_tready_i)                                  m_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    case (state_q)
      ST_IDLE: begin
        item_q  <= item_i;
        cnt_q   <= '0;
        rdval_q <= '0;
        a0_q    <= DW'(item_i.by_pos) - DW'(item_i.cy);
        b0_q    <= DW'(item_i.cx) - DW'(item_i.bx);
        a1_q    <= DW'(item_i.cy) - DW'(item_i.ay);
        b1_q    <= DW'(item_i.ax) - DW'(item_i.cx);
        c1_q    <= DW'(item_i.ay) - DW'(item_i.cy);
        ga_q    <= $signed({1'b0, item_i.depth_a}) - $signed({1'b0, item_i.depth_c});
        gb_q    <= $signed({1'b0, item_i.depth_b}) - $signed({1'b0, item_i.depth_c});
        minx_q  <= XW'(minx_c);
        maxx_q  <= XW'(maxx_c);
        miny_q  <= YW'(miny_c);
        maxy_q  <= YW'(maxy_c);
        empty_q <= (minx_c > maxx_c) || (miny_c > maxy_c);
      end
      ST_SETUP: begin
        case (step_q)
          4'd0: begin
            px_q       <= minx_q;
            py_q       <= miny_q;
            cx0_q      <= CXW'($signed({1'b0, minx_q, 4'd8})) - CXW'(item_q.cx);
            cy0_q      <= CXW'($signed({1'b0, miny_q, 4'd8})) - CXW'(item_q.cy);
            addr_row_q <= AW'(32'(miny_q) * MAP_WIDTH + 32'(minx_q));
            addr_q     <= AW'(32'(miny_q) * MAP_WIDTH + 32'(minx_q));
          end
          4'd1:  det_q <= $signed(prod_q[DETW-1:0]);
          4'd2:  det_q <= det_q + $signed(prod_q[DETW-1:0]);
          4'd3: begin
            // fold the winding into the edge coefficients
            if (det_q < 0) begin
              det_q <= -det_q;
              a0_q  <= -a0_q;
              b0_q  <= -b0_q;
              a1_q  <= -a1_q;
              b1_q  <= -b1_q;
            end
          end
          4'd5:  gx_q <= $signed(prod_q[MA_W-1:0]);
          4'd6:  gx_q <= gx_q + $signed(prod_q[MA_W-1:0]);
          4'd7:  gy_q <= $signed(prod_q[MA_W-1:0]);
          4'd8:  gy_q <= gy_q + $signed(prod_q[MA_W-1:0]);
          4'd9:  begin e0_q <= EW'(prod_q); e0r_q <= EW'(prod_q); end
          4'd10: begin e0_q <= e0_q + EW'(prod_q); e0r_q <= e0_q + EW'(prod_q); end
          4'd11: begin e1_q <= EW'(prod_q); e1r_q <= EW'(prod_q); end
          4'd12: begin e1_q <= e1_q + EW'(prod_q); e1r_q <= e1_q + EW'(prod_q); end
          4'd13: begin n_q <= NW'(prod_q); nr_q <= NW'(prod_q); end
          4'd14, 4'd15: begin
            n_q  <= n_q + NW'(prod_q);
            nr_q <= n_q + NW'(prod_q);
          end
          default: ;
        endcase
      end
      ST_PIX: begin
        if (covered) begin
          rem_q <= $unsigned(n_q + NW'(det_q >>> 1));
          dvs_q <= NW'($unsigned(det_q)) << (QW - 1);
          bit_q <= 4'(QW - 1);
        end
      end
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[QW-2:0], div_ge};
        dvs_q <= dvs_q >> 1;
        bit_q <= bit_q - 4'd1;
      end
      ST_WRITE:  if (quo_q < rd_data_q) cnt_q <= cnt_q + PIXCNT_W'(1);
      ST_RDWAIT: rdval_q <= rd_ok ? rd_data_q : '0;
      ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          res_cnt_q   <= cnt_q;
          res_depth_q <= rdval_q;
        end
      end
      default: ;
    endcase

    // step to the next pixel of the box
    if (adv && !(last_x && last_y)) begin
      if (last_x) begin
        px_q       <= minx_q;
        py_q       <= py_q + YW'(1);
        e0r_q      <= e0r_q + ey0;
        e1r_q      <= e1r_q + ey1;
        nr_q       <= nr_q + ny;
        e0_q       <= e0r_q + ey0;
        e1_q       <= e1r_q + ey1;
        n_q        <= nr_q + ny;
        addr_row_q <= addr_row_q + AW'(MAP_WIDTH);
        addr_q     <= addr_row_q + AW'(MAP_WIDTH);
      end else begin
        px_q   <= px_q + XW'(1);
        e0_q   <= e0_q + ex0;
        e1_q   <= e1_q + ex1;
        n_q    <= n_q + nx;
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  assign stat_o.ready     = (state_q == ST_IDLE);
  assign stat_o.init_busy = init_q;
  assign m_tvalid_o       = m_valid_q;
  assign pixels_written_o = res_cnt_q;
  assign read_depth_o     = res_depth_q;

  // the store is written only by the sweep or a passing depth test
  a_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
    else $error("depth store written outside clear or write");

  // the walk starts only on a nonzero determinant with positive winding
  a_det_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP && state_d == ST_PIX) |-> (det_q > 0))
    else $error("walk started with non-positive determinant");

  // the divide leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (rem_q < NW'($unsigned(det_q))))
    else $error("depth divide remainder out of range");

  // no item is taken during the clearing pass after reset
  a_init_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> (state_q == ST_CLEAR))
    else $error("item taken during initial clear");

endmodule

FILE: hdl/triangle_depth_rasterizer_core.sv
// ----------------------------------------------------------------------------
// triangle_depth_rasterizer_core
// Depth-only triangle rasterizer with an on-chip depth store for a shadow map.
//
//   port group  dir  payload
//   s_axis      in   tuser: cmd; tdata: vertices, depths, read pixel
//   m_axis      out  tdata: pixels_written, read_depth
//
// Triangle: setup on the shared multiplier, then a walk over the box pixels;
//   a covered pixel adds a bit-serial depth divide plus store read and write.
// Clear: one store entry per cycle, MAP_WIDTH*MAP_HEIGHT entries in all.
// Read: through the registered store read port.
// After reset a clearing pass over all MAP_WIDTH*MAP_HEIGHT entries runs
//   with s_axis_tready low. A two-word input queue and the output register
//   decouple the sides: the queue takes words while the output stalls, until full.
// ----------------------------------------------------------------------------
module triangle_depth_rasterizer_core
  import trd_pkg::*;
#(
  parameter int MAP_WIDTH  = DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT = DEF_MAP_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // ax, ay, bx, by_pos, cx, cy, depth_a, depth_b, depth_c, read_col, read_row
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // pixels_written, read_depth, zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  back_stat_t          stat;
  item_t               item;
  logic                item_valid;
  logic [PIXCNT_W-1:0] pixels_written;
  logic [DEPTH_W-1:0]  read_depth;

  trd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .stat_i       (stat),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  trd_back #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_i           (item),
    .stat_o           (stat),
    .m_tvalid_o       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .pixels_written_o (pixels_written),
    .read_depth_o     (read_depth)
  );

  assign m_axis_tdata = {{(M_TDATA_W - PIXCNT_W - DEPTH_W){1'b0}}, read_depth, pixels_written};

endmodule
